/* src/lkvc_pkg.sv */
package lkvc_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  // Configuration port
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam logic        REG_CAPACITY_LIMIT = 1'b0;   // word index, paddr[2]
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic signed [KEY_W-1:0]    lookup_key;
    logic        [DATA_W-1:0]   write_value;
  } req_t;

  typedef struct packed {
    logic                       hit;
    logic        [DATA_W-1:0]   read_value;
    logic                       evicted;
    logic signed [KEY_W-1:0]    evicted_key;
    logic        [COUNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

/* src/lkvc_ram.sv */
module lkvc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/lru_key_value_cache_core.sv */
// Channel   Direction  Handshake                   Payload
// config    in/out     psel/penable/pwrite/pready  paddr, pwdata, prdata (capacity_limit)
// request   in         in_valid_i / in_ready_o     in_data_i  (req_t)
// response  out        out_valid_o / out_ready_i   out_data_o (rsp_t)
//
// Entries sit in one RAM in recency order, most recent at address 0. A get or
// put scans from the front one entry a cycle, then shifts the entries above the
// hit (or the whole list on an insert) down one place and writes the front.
// A put miss scans and shifts the whole list, a get miss only scans it, and a
// put into an empty store writes the front directly. Clear and no-op go
// straight to the response without touching the RAM.
// Reset empties the store at once (fill count only, no clearing pass).
// One request is in flight at a time; a stalled response holds the block
// in its final state, but a new request is taken while the last beat waits.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_data_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = KEY_W + VALUE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_FRONT = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CAP_W-1:0]      cap_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;

  opcode_e               op_q, op_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [VALUE_BITS-1:0] front_val_q, front_val_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  res_hit_q, res_hit_d;
  logic [DATA_W-1:0]     res_val_q, res_val_d;
  logic                  res_ev_q, res_ev_d;
  logic [KEY_W-1:0]      res_evk_q, res_evk_d;

  logic [CW-1:0]         eff_cap;
  logic [CW-1:0]         trim_cnt;
  logic [CW-1:0]         idx_next_cnt;
  logic [AW-1:0]         idx_dec;
  logic [KEY_W-1:0]      rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  match;
  logic                  evict;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [RW-1:0]         ram_wdata, ram_rdata;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY_LIMIT)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY_LIMIT) ? APB_DW'(cap_q) : '0;

  // Clamp capacity to 1..ENTRIES and trim the held count to it
  always_comb begin
    if (32'(cap_q) > ENTRIES) begin
      eff_cap = CW'(ENTRIES);
    end else if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else begin
      eff_cap = CW'(cap_q);
    end
    trim_cnt = (cnt_q > eff_cap) ? eff_cap : cnt_q;
  end

  assign rd_key       = ram_rdata[RW-1:VALUE_BITS];
  assign rd_val       = ram_rdata[VALUE_BITS-1:0];
  assign match        = (rd_key == key_q);
  assign idx_next_cnt = CW'(idx_q) + CW'(1);
  assign idx_dec      = idx_q - AW'(1);
  assign evict        = (cnt_q >= eff_cap);

  // Sequencer: scan, shift down, write front, respond
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    op_d        = op_q;
    key_d       = key_q;
    front_val_d = front_val_q;
    idx_d       = idx_q;
    res_hit_d   = res_hit_q;
    res_val_d   = res_val_q;
    res_ev_d    = res_ev_q;
    res_evk_d   = res_evk_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    in_ready_o  = (state_q == ST_IDLE);

    // Drop the response beat once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d        = in_data_i.opcode;
          key_d       = in_data_i.lookup_key;
          front_val_d = VALUE_BITS'(in_data_i.write_value);
          idx_d       = '0;
          res_hit_d   = 1'b0;
          res_val_d   = '0;
          res_ev_d    = 1'b0;
          res_evk_d   = '0;
          cnt_d       = trim_cnt;
          case (in_data_i.opcode)
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_RESP;
            end
            OP_GET: begin
              if (trim_cnt == '0) begin
                state_d = ST_RESP;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_SCAN;
              end
            end
            OP_PUT: begin
              if (trim_cnt == '0) begin
                cnt_d   = CW'(1);
                state_d = ST_FRONT;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (match) begin
          res_hit_d = 1'b1;
          if (op_q == OP_GET) begin
            res_val_d   = DATA_W'(rd_val);
            front_val_d = rd_val;
          end
          idx_d = idx_q;
          if (idx_q == '0) begin
            state_d = ST_FRONT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_dec;
            state_d   = ST_SHIFT;
          end
        end else if (idx_next_cnt == cnt_q) begin
          if (op_q == OP_PUT) begin
            // Insert: evict the tail when full, then shift the list down
            if (evict) begin
              res_ev_d  = 1'b1;
              res_evk_d = rd_key;
              idx_d     = idx_q;
            end else begin
              cnt_d = cnt_q + CW'(1);
              idx_d = AW'(idx_next_cnt);
            end
            if (evict && (idx_q == '0)) begin
              state_d = ST_FRONT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = evict ? idx_dec : idx_q;
              state_d   = ST_SHIFT;
            end
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          // Advance to the next entry
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_next_cnt);
          idx_d     = AW'(idx_next_cnt);
        end
      end

      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if (idx_q == AW'(1)) begin
          state_d = ST_FRONT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec - AW'(1);
          idx_d     = idx_dec;
        end
      end

      ST_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {key_q, front_val_q};
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        // Hold until the response register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.hit         = res_hit_q;
          out_d.read_value  = res_val_q;
          out_d.evicted     = res_ev_q;
          out_d.evicted_key = res_evk_q;
          out_d.entry_count = COUNT_W'(cnt_q);
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    op_q        <= op_d;
    key_q       <= key_d;
    front_val_q <= front_val_d;
    idx_q       <= idx_d;
    res_hit_q   <= res_hit_d;
    res_val_q   <= res_val_d;
    res_ev_q    <= res_ev_d;
    res_evk_q   <= res_evk_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  lkvc_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* src/lkvc_checker.sv */
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // A stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response beat changed while stalled");

  // One request at a time: busy after a request beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // A new response only appears at the end of request work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response raised without request work");

  // A key already present is never evicted by its own put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> !out_data_o.evicted)
    else $error("eviction reported on a hit");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);
